### hw/rtl/tccw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

    // Frame store geometry.
    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 32;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = $clog2(DEPTH);
    // Counter width that can hold the depth itself.
    localparam int CNT_W    = ADDR_W + 1;
    // Effective column count (0..MAX_COLS) and row count (1..MAX_ROWS).
    localparam int COL_W    = $clog2(MAX_COLS + 1);
    localparam int NR_W     = $clog2(MAX_ROWS + 1);
    // Working row: cursor row plus one newline plus the largest wrap.
    localparam int WROW_W   = $clog2(MAX_ROWS + MAX_COLS + 1);

    // Fixed field widths.
    localparam int CH_W     = 8;
    localparam int CCOL_W   = 7;
    localparam int CROW_W   = 5;
    localparam int CELL_W   = 16;

    // Register reset values and indexes.
    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [5:0] ROWS_RESET = 6'd25;
    localparam logic       REG_COLS   = 1'b0;
    localparam logic       REG_ROWS   = 1'b1;

    // Item modes.
    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Control characters.
    localparam logic [CH_W-1:0] CHR_NUL = 8'h00;
    localparam logic [CH_W-1:0] CHR_BS  = 8'h08;
    localparam logic [CH_W-1:0] CHR_TAB = 8'h09;
    localparam logic [CH_W-1:0] CHR_LF  = 8'h0A;
    localparam logic [CH_W-1:0] CHR_CR  = 8'h0D;

    localparam logic [CELL_W-1:0] CELL_ATTR = 16'h0700;
    localparam int                TAB_STEP  = 8;

    localparam logic STAT_DONE    = 1'b0;
    localparam logic STAT_IGNORED = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_MEM,
        ST_RD_DATA,
        ST_PUT_ADDR,
        ST_PUT_AREA,
        ST_PUT_STORE,
        ST_DIV,
        ST_DIV_END,
        ST_ROW_CHECK,
        ST_SCR_OFF,
        ST_SCR_KEEP,
        ST_SCROLL,
        ST_COMMIT,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/text_console_char_writer.sv
// Text console writer: each input item either prints one character (or acts on a control
// code) at the cursor of a 128 x 32 frame store of 16-bit cells, or reads back one cell, and
// every item gives exactly one result item with a status, the cursor and the cell read.
// Items are handled one at a time through a single frame-store memory with a registered read
// port. A read steps through address, memory-read and data states and a put through address,
// area, store, row-check and commit states before the result. A put whose column runs past the
// row end also runs the bit-serial column divider. A put that runs past the bottom row scrolls
// the store, one cell per cycle through the memory port. After reset the block clears all 4096
// cells of the store and takes no item meanwhile; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer (
    input  wire         aclk,
    input  wire         aresetn,
    // Configuration writes.
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire  [7:0]  cfg_data,
    // Input items.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,  // character[7:0], read_row[12:8], read_col[19:13]
    input  wire  [0:0]  s_tuser,  // mode[0]
    // Result items.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,  // cursor_column[6:0], cursor_line[11:7], cell_value[27:12]
    output logic [0:0]  m_tuser   // status[0]
);

    localparam int AW = tccw_pkg::ADDR_W;
    localparam int CW = tccw_pkg::CNT_W;
    localparam int KW = tccw_pkg::COL_W;
    localparam int RW = tccw_pkg::NR_W;
    localparam int WW = tccw_pkg::WROW_W;

    tccw_pkg::state_t state_reg, state_next;

    // Configuration registers and cursor.
    logic [7:0]                   cols_reg, cols_next;
    logic [5:0]                   rows_reg, rows_next;
    logic [tccw_pkg::CCOL_W-1:0]  cur_col_reg, cur_col_next;
    logic [tccw_pkg::CROW_W-1:0]  cur_row_reg, cur_row_next;

    // Latched item.
    logic                         mode_reg, mode_next;
    logic [tccw_pkg::CH_W-1:0]    ch_reg, ch_next;
    logic [tccw_pkg::CROW_W-1:0]  rr_reg, rr_next;
    logic [tccw_pkg::CCOL_W-1:0]  rc_reg, rc_next;
    logic [KW-1:0]                nc_reg, nc_next;
    logic [RW-1:0]                nr_reg, nr_next;

    // Working values.
    logic [KW-1:0]                col_reg, col_next;
    logic [WW-1:0]                row_reg, row_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic [CW-1:0]                area_reg, area_next;
    logic                         print_reg, print_next;
    logic                         rd_ok_reg, rd_ok_next;
    logic [KW-1:0]                rem_reg, rem_next;
    logic [2:0]                   div_cnt_reg, div_cnt_next;
    logic [RW-1:0]                shift_reg, shift_next;
    logic [CW-1:0]                src_off_reg, src_off_next;
    logic [CW-1:0]                copy_end_reg, copy_end_next;
    logic [CW-1:0]                sweep_reg, sweep_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic                         pend_copy_reg, pend_copy_next;
    logic [AW-1:0]                pend_addr_reg, pend_addr_next;
    logic                         stat_reg, stat_next;
    logic [tccw_pkg::CELL_W-1:0]  cell_reg, cell_next;

    // Result register.
    logic                         out_valid_reg, out_valid_next;
    logic                         out_stat_reg, out_stat_next;
    logic [tccw_pkg::CCOL_W-1:0]  out_col_reg, out_col_next;
    logic [tccw_pkg::CROW_W-1:0]  out_row_reg, out_row_next;
    logic [tccw_pkg::CELL_W-1:0]  out_cell_reg, out_cell_next;

    // Frame store.
    logic [tccw_pkg::CELL_W-1:0]  mem [tccw_pkg::DEPTH];
    logic [tccw_pkg::CELL_W-1:0]  rdata_reg;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [tccw_pkg::CELL_W-1:0]  mem_wdata;
    logic [AW-1:0]                mem_raddr;

    // Handshakes and unpacked fields.
    logic                         in_fire;
    logic                         out_free;
    logic [KW-1:0]                nc_eff;
    logic [RW-1:0]                nr_eff;
    logic [KW-1:0]                cur_col_w;
    logic [KW-1:0]                tab_col;
    logic [KW-1:0]                rem_shift;
    logic                         rem_ge;
    logic [WW-1:0]                shift_raw;
    logic                         sweep_live;
    logic                         sweep_copy;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == tccw_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_stat_reg;
    assign m_tdata   = {4'b0000, out_cell_reg, out_row_reg, out_col_reg};

    // Effective geometry from the registers.
    always_comb begin
        if (cols_reg > 8'(tccw_pkg::MAX_COLS)) begin
            nc_eff = KW'(tccw_pkg::MAX_COLS);
        end else begin
            nc_eff = KW'(cols_reg);
        end
        if (rows_reg == 6'd0) begin
            nr_eff = RW'(1);
        end else if (rows_reg > 6'(tccw_pkg::MAX_ROWS)) begin
            nr_eff = RW'(tccw_pkg::MAX_ROWS);
        end else begin
            nr_eff = RW'(rows_reg);
        end
    end

    // Column arithmetic, divider step and scroll sweep helpers.
    assign cur_col_w  = KW'(cur_col_reg);
    assign tab_col    = (cur_col_w + KW'(tccw_pkg::TAB_STEP)) & ~KW'(tccw_pkg::TAB_STEP - 1);
    assign rem_shift  = {rem_reg[KW-2:0], col_reg[KW-1]};
    assign rem_ge     = (rem_shift >= nc_reg);
    assign shift_raw  = row_reg - WW'(nr_reg) + WW'(1);
    assign sweep_live = (sweep_reg < area_reg);
    assign sweep_copy = (sweep_reg < copy_end_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tccw_pkg::ST_CLEAR: begin
                if (sweep_reg == CW'(tccw_pkg::DEPTH - 1)) begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (s_tuser[0] == tccw_pkg::MODE_READ) begin
                        state_next = tccw_pkg::ST_RD_ADDR;
                    end else if (nc_eff == '0 || s_tdata[7:0] == tccw_pkg::CHR_NUL) begin
                        state_next = tccw_pkg::ST_RESULT;
                    end else begin
                        state_next = tccw_pkg::ST_PUT_ADDR;
                    end
                end
            end
            tccw_pkg::ST_RD_ADDR:   state_next = tccw_pkg::ST_RD_MEM;
            tccw_pkg::ST_RD_MEM:    state_next = tccw_pkg::ST_RD_DATA;
            tccw_pkg::ST_RD_DATA:   state_next = tccw_pkg::ST_RESULT;
            tccw_pkg::ST_PUT_ADDR:  state_next = tccw_pkg::ST_PUT_AREA;
            tccw_pkg::ST_PUT_AREA:  state_next = tccw_pkg::ST_PUT_STORE;
            tccw_pkg::ST_PUT_STORE: begin
                if (col_reg >= nc_reg) begin
                    state_next = tccw_pkg::ST_DIV;
                end else begin
                    state_next = tccw_pkg::ST_ROW_CHECK;
                end
            end
            tccw_pkg::ST_DIV: begin
                if (div_cnt_reg == 3'd7) begin
                    state_next = tccw_pkg::ST_DIV_END;
                end
            end
            tccw_pkg::ST_DIV_END:   state_next = tccw_pkg::ST_ROW_CHECK;
            tccw_pkg::ST_ROW_CHECK: begin
                if (row_reg >= WW'(nr_reg)) begin
                    state_next = tccw_pkg::ST_SCR_OFF;
                end else begin
                    state_next = tccw_pkg::ST_COMMIT;
                end
            end
            tccw_pkg::ST_SCR_OFF:   state_next = tccw_pkg::ST_SCR_KEEP;
            tccw_pkg::ST_SCR_KEEP:  state_next = tccw_pkg::ST_SCROLL;
            tccw_pkg::ST_SCROLL: begin
                if (!sweep_live) begin
                    state_next = tccw_pkg::ST_COMMIT;
                end
            end
            tccw_pkg::ST_COMMIT:    state_next = tccw_pkg::ST_RESULT;
            tccw_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            default:                state_next = tccw_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory controls and result register.
    always_comb begin
        cols_next       = cols_reg;
        rows_next       = rows_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        mode_next       = mode_reg;
        ch_next         = ch_reg;
        rr_next         = rr_reg;
        rc_next         = rc_reg;
        nc_next         = nc_reg;
        nr_next         = nr_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        idx_next        = idx_reg;
        area_next       = area_reg;
        print_next      = print_reg;
        rd_ok_next      = rd_ok_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        shift_next      = shift_reg;
        src_off_next    = src_off_reg;
        copy_end_next   = copy_end_reg;
        sweep_next      = sweep_reg;
        pend_valid_next = pend_valid_reg;
        pend_copy_next  = pend_copy_reg;
        pend_addr_next  = pend_addr_reg;
        stat_next       = stat_reg;
        cell_next       = cell_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_stat_next   = out_stat_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        out_cell_next   = out_cell_reg;
        mem_we          = 1'b0;
        mem_waddr       = pend_addr_reg;
        mem_wdata       = '0;
        mem_raddr       = idx_reg[AW-1:0];

        // Configuration writes.
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == tccw_pkg::REG_COLS) begin
                cols_next = cfg_data;
            end else begin
                rows_next = cfg_data[5:0];
            end
        end

        // A pending scroll write lands in the cycle after its source read.
        if (pend_valid_reg) begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = pend_copy_reg ? rdata_reg : '0;
        end

        case (state_reg)
            tccw_pkg::ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg[AW-1:0];
                mem_wdata  = '0;
                sweep_next = sweep_reg + CW'(1);
            end
            tccw_pkg::ST_IDLE: begin
                if (in_fire) begin
                    mode_next = s_tuser[0];
                    ch_next   = s_tdata[7:0];
                    rr_next   = s_tdata[12:8];
                    rc_next   = s_tdata[19:13];
                    nc_next   = nc_eff;
                    nr_next   = nr_eff;
                    cell_next = '0;
                    if (s_tuser[0] == tccw_pkg::MODE_PUT
                            && (nc_eff == '0 || s_tdata[7:0] == tccw_pkg::CHR_NUL)) begin
                        stat_next = tccw_pkg::STAT_IGNORED;
                    end else begin
                        stat_next = tccw_pkg::STAT_DONE;
                    end
                end
            end
            tccw_pkg::ST_RD_ADDR: begin
                idx_next   = CW'(rr_reg) * CW'(nc_reg) + CW'(rc_reg);
                rd_ok_next = (KW'(rc_reg) < nc_reg) && (RW'(rr_reg) < nr_reg);
            end
            tccw_pkg::ST_RD_MEM: begin
                mem_raddr = idx_reg[AW-1:0];
            end
            tccw_pkg::ST_RD_DATA: begin
                cell_next = rd_ok_reg ? rdata_reg : '0;
            end
            tccw_pkg::ST_PUT_ADDR: begin
                // Cell address of the cursor and the cursor move of the character.
                idx_next   = CW'(cur_row_reg) * CW'(nc_reg) + CW'(cur_col_reg);
                print_next = 1'b0;
                row_next   = WW'(cur_row_reg);
                col_next   = cur_col_w;
                case (ch_reg)
                    tccw_pkg::CHR_LF: begin
                        row_next = WW'(cur_row_reg) + WW'(1);
                        col_next = '0;
                    end
                    tccw_pkg::CHR_CR: begin
                        col_next = '0;
                    end
                    tccw_pkg::CHR_TAB: begin
                        col_next = tab_col;
                    end
                    tccw_pkg::CHR_BS: begin
                        if (cur_col_reg != '0) begin
                            col_next = cur_col_w - KW'(1);
                        end
                    end
                    default: begin
                        print_next = 1'b1;
                        col_next   = cur_col_w + KW'(1);
                    end
                endcase
            end
            tccw_pkg::ST_PUT_AREA: begin
                area_next = CW'(nc_reg) * CW'(nr_reg);
            end
            tccw_pkg::ST_PUT_STORE: begin
                // Only cells inside the area in use are written.
                if (print_reg && idx_reg < area_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg[AW-1:0];
                    mem_wdata = tccw_pkg::CELL_ATTR | tccw_pkg::CELL_W'(ch_reg);
                end
                rem_next     = '0;
                div_cnt_next = '0;
            end
            tccw_pkg::ST_DIV: begin
                // Restoring division of the column by the column count, one bit a cycle.
                rem_next     = rem_ge ? (rem_shift - nc_reg) : rem_shift;
                col_next     = {col_reg[KW-2:0], rem_ge};
                div_cnt_next = div_cnt_reg + 3'd1;
            end
            tccw_pkg::ST_DIV_END: begin
                row_next = row_reg + WW'(col_reg);
                col_next = rem_reg;
            end
            tccw_pkg::ST_ROW_CHECK: begin
                if (shift_raw > WW'(nr_reg)) begin
                    shift_next = nr_reg;
                end else begin
                    shift_next = RW'(shift_raw);
                end
            end
            tccw_pkg::ST_SCR_OFF: begin
                src_off_next = CW'(shift_reg) * CW'(nc_reg);
            end
            tccw_pkg::ST_SCR_KEEP: begin
                copy_end_next   = CW'(nr_reg - shift_reg) * CW'(nc_reg);
                sweep_next      = '0;
                pend_valid_next = 1'b0;
                row_next        = WW'(nr_reg) - WW'(1);
            end
            tccw_pkg::ST_SCROLL: begin
                // Move kept rows up and clear the freed ones, one cell a cycle.
                if (sweep_live) begin
                    pend_valid_next = 1'b1;
                    pend_copy_next  = sweep_copy;
                    pend_addr_next  = sweep_reg[AW-1:0];
                    mem_raddr       = AW'(sweep_reg + src_off_reg);
                    sweep_next      = sweep_reg + CW'(1);
                end else begin
                    pend_valid_next = 1'b0;
                end
            end
            tccw_pkg::ST_COMMIT: begin
                cur_col_next = col_reg[tccw_pkg::CCOL_W-1:0];
                cur_row_next = row_reg[tccw_pkg::CROW_W-1:0];
            end
            tccw_pkg::ST_RESULT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_col_next   = cur_col_reg;
                    out_row_next   = cur_row_reg;
                    out_cell_next  = cell_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tccw_pkg::ST_CLEAR;
            cols_reg       <= tccw_pkg::COLS_RESET;
            rows_reg       <= tccw_pkg::ROWS_RESET;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            sweep_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cols_reg       <= cols_next;
            rows_reg       <= rows_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            sweep_reg      <= sweep_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        ch_reg        <= ch_next;
        rr_reg        <= rr_next;
        rc_reg        <= rc_next;
        nc_reg        <= nc_next;
        nr_reg        <= nr_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        idx_reg       <= idx_next;
        area_reg      <= area_next;
        print_reg     <= print_next;
        rd_ok_reg     <= rd_ok_next;
        rem_reg       <= rem_next;
        div_cnt_reg   <= div_cnt_next;
        shift_reg     <= shift_next;
        src_off_reg   <= src_off_next;
        copy_end_reg  <= copy_end_next;
        pend_copy_reg <= pend_copy_next;
        pend_addr_reg <= pend_addr_next;
        stat_reg      <= stat_next;
        cell_reg      <= cell_next;
        out_stat_reg  <= out_stat_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
        out_cell_reg  <= out_cell_next;
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // The mode is fixed by the state path taken; keep it for the item record.
    logic mode_unused;
    assign mode_unused = mode_reg;

endmodule

`default_nettype wire
